/* rtl/core/wfa_pkg.sv */
// Shared types and constants for the worst-fit allocator core.
// Used by wfa_cell and worst_fit_allocator_core; no dependencies.
package wfa_pkg;

  localparam int SIZE_W         = 16;
  localparam int SLOT_W         = 6;
  localparam int COUNT_W        = 7;
  localparam int TOTAL_W        = 22;
  localparam int HOLE_SLOTS_DEF = 64;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_REQ  = 1'b1;

  // Record that travels down the row of cells, one cell per cycle.
  typedef struct packed {
    logic               vld;
    logic               search;     // 1: worst-fit search, 0: free-space sum
    logic               found;
    logic [SIZE_W-1:0]  best_size;
    logic [TOTAL_W-1:0] sum;
  } wave_t;

  // Values broadcast from the controller to every cell.
  typedef struct packed {
    logic              wr_en;
    logic [SIZE_W-1:0] wr_data;
    logic [SIZE_W-1:0] req_size;
  } bcast_t;

endpackage

/* rtl/core/worst_fit_allocator_core.sv */
// Worst-fit hole allocator: controller plus a row of wfa_cell slots.
// Depends on wfa_pkg and wfa_cell.
//
// Usage:
//   in_*  channel carries one transaction per item. in_tuser is the opcode
//   (load a hole size or request an allocation), in_tlast marks the last
//   request of a run. Every item produces exactly one out_* transaction.
//   cfg_wr_en/cfg_wr_data set the number of hole slots in use; write it
//   only while the block is idle.
// Sequence:
//   A record walks the row of HOLE_SLOTS cells, one cell per cycle. A load
//   takes one walk (free-space sum), a request two (worst-fit search, then
//   the sum after the hole is shrunk). out_tvalid rises when the result
//   moves from S_DONE into the output register, and the next item is
//   accepted from that same cycle. One item is in work at a time.
// Reset: rst_n (synchronous, active low) clears all hole sizes and the
//   slot count to zero and drops out_tvalid.
// Stall: a finished result waits in the output register while out_tready
//   is low; the next item is already accepted and worked on, and its
//   result holds in the controller until the output register frees up.
module worst_fit_allocator_core import wfa_pkg::*; #(
  parameter int HOLE_SLOTS = HOLE_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // cfg: hole_count
  input  logic               cfg_wr_en,
  input  logic [COUNT_W-1:0] cfg_wr_data,
  // in: tdata = slot_index[5:0], size[21:6], zero[23:22]; tuser = opcode
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [23:0]        in_tdata,
  input  logic               in_tuser,
  input  logic               in_tlast,
  // out: tdata = chosen_hole[5:0], remaining[21:6], total_free[43:22],
  //      zero[47:44]; tuser = granted; tlast = run_done
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [47:0]        out_tdata,
  output logic               out_tuser,
  output logic               out_tlast
);

  localparam int IDXW = (HOLE_SLOTS > 1) ? $clog2(HOLE_SLOTS) : 1;
  localparam int CNTW = $clog2(HOLE_SLOTS + 1);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SRCH_GO   = 3'd1;
  localparam logic [2:0] S_SRCH_WAIT = 3'd2;
  localparam logic [2:0] S_APPLY     = 3'd3;
  localparam logic [2:0] S_SUM_GO    = 3'd4;
  localparam logic [2:0] S_SUM_WAIT  = 3'd5;
  localparam logic [2:0] S_DONE      = 3'd6;

  logic [2:0]          state_r;
  logic [2:0]          state_nxt;
  logic [COUNT_W-1:0]  cfg_r;
  logic                op_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [SIZE_W-1:0]   req_r;
  logic                last_r;
  logic                found_r;
  logic [IDXW-1:0]     best_idx_r;
  logic [SIZE_W-1:0]   best_size_r;
  logic                granted_r;
  logic [SLOT_W-1:0]   chosen_r;
  logic [SIZE_W-1:0]   remain_r;
  logic [TOTAL_W-1:0]  total_r;
  logic                out_vld_r;
  logic                out_vld_nxt;
  logic [47:0]         out_data_r;
  logic                out_user_r;
  logic                out_last_r;

  logic                in_acc;
  logic                out_free;
  logic                slot_ok;
  logic [SIZE_W-1:0]   shrunk;
  logic [CNTW-1:0]     n_used;
  bcast_t              ctl;
  logic [IDXW-1:0]     wr_idx;

  wave_t               wave_chain [HOLE_SLOTS+1];
  logic [IDXW-1:0]     idx_chain  [HOLE_SLOTS+1];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_vld_r || out_tready;
  assign slot_ok   = ({{(32 - SLOT_W){1'b0}}, slot_r} < 32'(HOLE_SLOTS));
  assign shrunk    = best_size_r - req_r;
  assign n_used    = ({{(32 - COUNT_W){1'b0}}, cfg_r} > 32'(HOLE_SLOTS)) ?
                     CNTW'(HOLE_SLOTS) : CNTW'(cfg_r);

  // broadcast to the cells; writes happen only while no record is in flight
  always_comb begin
    ctl.req_size = req_r;
    ctl.wr_en    = 1'b0;
    ctl.wr_data  = req_r;
    wr_idx       = IDXW'(slot_r);
    if (state_r == S_APPLY) begin
      if (op_r == OP_LOAD) begin
        ctl.wr_en = slot_ok;
      end else begin
        ctl.wr_en   = found_r;
        ctl.wr_data = shrunk;
        wr_idx      = best_idx_r;
      end
    end
  end

  assign wave_chain[0].vld       = (state_r == S_SRCH_GO) || (state_r == S_SUM_GO);
  assign wave_chain[0].search    = (state_r == S_SRCH_GO);
  assign wave_chain[0].found     = 1'b0;
  assign wave_chain[0].best_size = '0;
  assign wave_chain[0].sum       = '0;
  assign idx_chain[0]            = '0;

  for (genvar i = 0; i < HOLE_SLOTS; i++) begin : g_cell
    wfa_cell #(
      .IDX  (i),
      .IDXW (IDXW),
      .CNTW (CNTW)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .wr_idx (wr_idx),
      .n_used (n_used),
      .wave_i (wave_chain[i]),
      .idx_i  (idx_chain[i]),
      .wave_o (wave_chain[i+1]),
      .idx_o  (idx_chain[i+1])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_tuser == OP_LOAD) ? S_APPLY : S_SRCH_GO;
        end
      end
      S_SRCH_GO:   state_nxt = S_SRCH_WAIT;
      S_SRCH_WAIT: begin
        if (wave_chain[HOLE_SLOTS].vld) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY:     state_nxt = S_SUM_GO;
      S_SUM_GO:    state_nxt = S_SUM_WAIT;
      S_SUM_WAIT:  begin
        if (wave_chain[HOLE_SLOTS].vld) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
    if (state_r == S_DONE && out_free) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cfg_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
    end
  end

  // transaction payload and per-item results
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_tuser;
      slot_r <= in_tdata[5:0];
      req_r  <= in_tdata[21:6];
      last_r <= in_tlast;
    end
    if (state_r == S_SRCH_WAIT && wave_chain[HOLE_SLOTS].vld) begin
      found_r     <= wave_chain[HOLE_SLOTS].found;
      best_size_r <= wave_chain[HOLE_SLOTS].best_size;
      best_idx_r  <= idx_chain[HOLE_SLOTS];
    end
    if (state_r == S_APPLY) begin
      if (op_r == OP_LOAD) begin
        granted_r <= 1'b0;
        chosen_r  <= slot_r;
        remain_r  <= slot_ok ? req_r : '0;
      end else begin
        granted_r <= found_r;
        chosen_r  <= found_r ? SLOT_W'(best_idx_r) : '0;
        remain_r  <= found_r ? shrunk : '0;
      end
    end
    if (state_r == S_SUM_WAIT && wave_chain[HOLE_SLOTS].vld) begin
      total_r <= wave_chain[HOLE_SLOTS].sum;
    end
    if (state_r == S_DONE && out_free) begin
      out_data_r <= {4'b0000, total_r, remain_r, chosen_r};
      out_user_r <= granted_r;
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  // a record leaves the row only while the controller waits for it
  a_wave_expected: assert property (@(posedge clk) disable iff (!rst_n)
    wave_chain[HOLE_SLOTS].vld |-> (state_r == S_SRCH_WAIT || state_r == S_SUM_WAIT))
    else $error("record left the cell row outside a wait state");

  // an accepted transaction always starts work
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_APPLY || state_r == S_SRCH_GO))
    else $error("accepted transaction did not start");

  // a granted request never takes more than the chosen hole holds
  a_grant_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY && op_r == OP_REQ && found_r) |-> (best_size_r >= req_r))
    else $error("granted request larger than chosen hole");

  // the output register is loaded only once it is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready) |=> (out_vld_r && $stable(out_data_r)))
    else $error("pending result overwritten");

endmodule

/* rtl/core/wfa_cell.sv */
// One hole slot of the allocator row: holds a hole size and updates the
// passing search or sum record. Depends on wfa_pkg.
module wfa_cell import wfa_pkg::*; #(
  parameter int IDX  = 0,
  parameter int IDXW = 6,
  parameter int CNTW = 7
) (
  input  logic            clk,
  input  logic            rst_n,
  input  bcast_t          ctl,
  input  logic [IDXW-1:0] wr_idx,
  input  logic [CNTW-1:0] n_used,
  input  wave_t           wave_i,
  input  logic [IDXW-1:0] idx_i,
  output wave_t           wave_o,
  output logic [IDXW-1:0] idx_o
);

  logic [SIZE_W-1:0]  size_r;
  wave_t              wave_r;
  wave_t              wave_nxt;
  logic [IDXW-1:0]    idx_r;
  logic [IDXW-1:0]    idx_nxt;
  logic               in_use;
  logic [TOTAL_W:0]   sum_wide;

  assign in_use   = (CNTW'(IDX) < n_used);
  assign sum_wide = {1'b0, wave_i.sum} + {{(TOTAL_W + 1 - SIZE_W){1'b0}}, size_r};

  always_comb begin
    wave_nxt = wave_i;
    idx_nxt  = idx_i;
    if (wave_i.vld && in_use) begin
      if (wave_i.search) begin
        if (size_r >= ctl.req_size && (!wave_i.found || size_r > wave_i.best_size)) begin
          wave_nxt.found     = 1'b1;
          wave_nxt.best_size = size_r;
          idx_nxt            = IDXW'(IDX);
        end
      end else begin
        // saturate the running total
        wave_nxt.sum = sum_wide[TOTAL_W] ? TOTAL_MAX : sum_wide[TOTAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    wave_r.search    <= wave_nxt.search;
    wave_r.found     <= wave_nxt.found;
    wave_r.best_size <= wave_nxt.best_size;
    wave_r.sum       <= wave_nxt.sum;
    idx_r            <= idx_nxt;
    if (!rst_n) begin
      size_r     <= '0;
      wave_r.vld <= 1'b0;
    end else begin
      if (ctl.wr_en && wr_idx == IDXW'(IDX)) begin
        size_r <= ctl.wr_data;
      end
      wave_r.vld <= wave_nxt.vld;
    end
  end

  assign wave_o = wave_r;
  assign idx_o  = idx_r;

endmodule

/* test/testbench.sv */
// Self-checking testbench for worst_fit_allocator_core: hole loads and worst-fit requests
// checked against an in-bench allocator model across several hole_count settings.
// Depends on wfa_pkg and the allocator RTL.
module testbench;
  import wfa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLE_SLOTS  = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int IDLE_PCT    = 24;

  typedef struct packed {
    logic              op;
    logic [SLOT_W-1:0] slot;
    logic [SIZE_W-1:0] size;
    logic              last;
  } hole_item_t;

  typedef struct packed {
    logic               granted;
    logic [SLOT_W-1:0]  chosen;
    logic [SIZE_W-1:0]  remaining;
    logic [TOTAL_W-1:0] total;
    logic               run_done;
  } alloc_result_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [COUNT_W-1:0] cfg_wr_data;
  logic               in_tvalid;
  logic               in_tready;
  logic [23:0]        in_tdata;
  logic               in_tuser;
  logic               in_tlast;
  logic               out_tvalid;
  logic               out_tready;
  logic [47:0]        out_tdata;
  logic               out_tuser;
  logic               out_tlast;

  worst_fit_allocator_core #(.HOLE_SLOTS(HOLE_SLOTS)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  // Allocator model state
  logic [SIZE_W-1:0] hole_table [HOLE_SLOTS];
  int                hole_limit;

  hole_item_t    item_queue[$];
  alloc_result_t alloc_expected[$];
  hole_item_t    presented;
  alloc_result_t want;
  alloc_result_t got;

  bit quiet;
  int errors;
  int cycles;
  int results_seen;
  int loads_done;
  int grants_done;
  int refusals_done;
  int settings_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic alloc_result_t predict_alloc(hole_item_t it);
    alloc_result_t r;
    int span;
    int best;
    int k;
    logic found;
    logic [SIZE_W-1:0] best_sz;
    logic [TOTAL_W:0] sum;
    r = '0;
    r.run_done = it.last;
    span = (hole_limit > HOLE_SLOTS) ? HOLE_SLOTS : hole_limit;
    if (it.op == OP_LOAD) begin
      r.chosen = it.slot;
      loads_done++;
      if (int'(it.slot) < HOLE_SLOTS) begin
        hole_table[it.slot] = it.size;
        r.remaining = it.size;
      end
    end else begin
      found = 1'b0;
      best = 0;
      best_sz = '0;
      for (k = 0; k < span; k++) begin
        // strict compare keeps the lowest index on a tie
        if (hole_table[k] >= it.size && (!found || hole_table[k] > best_sz)) begin
          found = 1'b1;
          best = k;
          best_sz = hole_table[k];
        end
      end
      if (found) begin
        hole_table[best] = best_sz - it.size;
        r.granted = 1'b1;
        r.chosen = best[SLOT_W-1:0];
        r.remaining = best_sz - it.size;
        grants_done++;
      end else begin
        refusals_done++;
      end
    end
    sum = '0;
    for (k = 0; k < span; k++) begin
      sum = sum + hole_table[k];
      if (sum > TOTAL_MAX) sum = TOTAL_MAX;
    end
    r.total = sum[TOTAL_W-1:0];
    return r;
  endfunction

  function automatic hole_item_t make_item(logic op, int slot, int size, logic last);
    hole_item_t it;
    it.op = op;
    it.slot = slot[SLOT_W-1:0];
    it.size = size[SIZE_W-1:0];
    it.last = last;
    return it;
  endfunction

  // Driver: present the next pending transaction once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= 1'b0;
      in_tlast  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        alloc_expected.push_back(predict_alloc(presented));
      end
      if (!in_tvalid || in_tready) begin
        if (item_queue.size() > 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          presented = item_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {2'b00, presented.size, presented.slot};
          in_tuser  <= presented.op;
          in_tlast  <= presented.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Monitor: random backpressure, compare each result with the oldest prediction
  always @(posedge clk) begin
    out_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      got.granted   = out_tuser;
      got.chosen    = out_tdata[5:0];
      got.remaining = out_tdata[21:6];
      got.total     = out_tdata[43:22];
      got.run_done  = out_tlast;
      if (alloc_expected.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = alloc_expected.pop_front();
        check_field("granted", want.granted, got.granted);
        check_field("chosen_hole", want.chosen, got.chosen);
        check_field("remaining", want.remaining, got.remaining);
        check_field("total_free", want.total, got.total);
        check_field("run_done", want.run_done, got.run_done);
        check_field("tdata pad", 0, out_tdata[47:44]);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, alloc_expected.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic drain;
    while (item_queue.size() != 0 || in_tvalid || alloc_expected.size() != 0)
      @(negedge clk);
  endtask

  // Write hole_count only once everything in flight has come back
  task automatic write_hole_count(int v);
    drain();
    repeat (4) @(negedge clk);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v[COUNT_W-1:0];
    hole_limit = v & 32'h7f;
    settings_done++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_random_items(int n);
    hole_item_t it;
    int span;
    int k;
    int pick;
    span = (hole_limit > HOLE_SLOTS) ? HOLE_SLOTS : hole_limit;
    // seed the first few holes so requests have something to find
    for (k = 0; k < span && k < 8; k++)
      item_queue.push_back(make_item(OP_LOAD, k, $urandom_range(65535), 1'b0));
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      it.last = ($urandom_range(7) == 0);
      if (pick < 35) begin
        it.op = OP_LOAD;
        it.slot = (span > 0 && $urandom_range(4) != 0) ? SLOT_W'($urandom_range(span - 1, 0))
                                                          : SLOT_W'($urandom_range(63));
        pick = $urandom_range(99);
        if (pick < 60) it.size = SIZE_W'($urandom_range(65535));
        else if (pick < 80) it.size = 16'hffff;
        else it.size = SIZE_W'($urandom_range(255));
      end else begin
        it.op = OP_REQ;
        it.slot = SLOT_W'($urandom_range(63));
        pick = $urandom_range(99);
        if (pick < 15) it.size = SIZE_W'($urandom_range(65535));
        else if (pick < 25) it.size = '0;
        else it.size = SIZE_W'($urandom_range(16000));
      end
      item_queue.push_back(it);
    end
  endtask

  initial begin
    int settings [8];
    int p;
    settings = '{3, 64, 1, 127, 16, 0, 40, 64};
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    quiet       = 1'b0;
    hole_limit  = 0;
    errors = 0;
    cycles = 0;
    results_seen = 0;
    loads_done = 0;
    grants_done = 0;
    refusals_done = 0;
    settings_done = 0;
    for (p = 0; p < HOLE_SLOTS; p++) hole_table[p] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // No slots in use: loads land but do not count, zero-size request is refused
    write_hole_count(0);
    item_queue.push_back(make_item(OP_LOAD, 63, 16'hffff, 1'b0));
    item_queue.push_back(make_item(OP_REQ, 0, 0, 1'b0));
    item_queue.push_back(make_item(OP_REQ, 63, 16'hffff, 1'b1));

    // Full table: ties, exact fit, zero-size request, refusal
    write_hole_count(64);
    item_queue.push_back(make_item(OP_LOAD, 0, 16'hffff, 1'b0));
    item_queue.push_back(make_item(OP_LOAD, 5, 16'hffff, 1'b0));
    item_queue.push_back(make_item(OP_LOAD, 42, 16'h5555, 1'b1));
    item_queue.push_back(make_item(OP_LOAD, 21, 16'h2aaa, 1'b0));
    item_queue.push_back(make_item(OP_REQ, 21, 16'hffff, 1'b0));
    item_queue.push_back(make_item(OP_REQ, 42, 0, 1'b0));
    item_queue.push_back(make_item(OP_REQ, 0, 16'hffff, 1'b1));
    item_queue.push_back(make_item(OP_REQ, 63, 16'h8000, 1'b0));
    item_queue.push_back(make_item(OP_REQ, 0, 1, 1'b0));
    item_queue.push_back(make_item(OP_LOAD, 63, 0, 1'b0));
    item_queue.push_back(make_item(OP_REQ, 0, 16'h5554, 1'b1));

    // Oversized count acts as the full row
    write_hole_count(127);
    item_queue.push_back(make_item(OP_LOAD, 63, 16'hffff, 1'b0));
    item_queue.push_back(make_item(OP_REQ, 0, 16'hfffe, 1'b0));
    item_queue.push_back(make_item(OP_REQ, 0, 0, 1'b1));

    for (p = 0; p < 8; p++) begin
      write_hole_count(settings[p]);
      quiet = (p == 1);
      queue_random_items(100);
    end

    drain();
    repeat (2 * HOLE_SLOTS + 10) @(negedge clk);
    $display("Checked %0d results: %0d loads, %0d granted and %0d refused requests",
             results_seen, loads_done, grants_done, refusals_done);
    $display("Exercised %0d hole_count settings from 0 up to 127", settings_done);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/wfa_pkg.sv
rtl/core/wfa_cell.sv
rtl/core/worst_fit_allocator_core.sv
test/testbench.sv
